FILE: rtl/tfn_pkg.sv
// Package for the triangle face normal unit: item modes and queue entry type.
// No dependencies.
package tfn_pkg;

  typedef enum logic {
    MODE_WRITE   = 1'b0,
    MODE_COMPUTE = 1'b1
  } mode_e;

  localparam int unsigned IdxW   = 8;
  localparam int unsigned NormW  = 10;
  localparam int unsigned FieldW = 12;

  // Compute item travelling from front to back.
  typedef struct packed {
    logic [IdxW-1:0] index_a;
    logic [IdxW-1:0] index_b;
    logic [IdxW-1:0] index_c;
  } job_t;

endpackage

FILE: rtl/tfn_front.sv
// Front part: accepts words, writes vertices, queues compute jobs.
// Depends on tfn_pkg.
module tfn_front import tfn_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_mode_i,
  input  job_t              in_job_i,
  output logic              wr_en_o,
  output job_t              job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  localparam int unsigned PW = $clog2(QDepth);

  job_t          q_mem [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  // A write waits until no compute is queued or running, so pending computes
  // always read the store as it was when they were taken.
  assign in_ready_o  = (in_mode_i == MODE_WRITE) ? (cnt_q == '0 && job_ready_i)
                                                 : (cnt_q != (PW+1)'(QDepth));
  assign wr_en_o     = in_valid_i && in_mode_i == MODE_WRITE && in_ready_o;
  assign push        = in_valid_i && in_mode_i == MODE_COMPUTE && in_ready_o;
  assign job_valid_o = cnt_q != '0;
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= in_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(QDepth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PW'(QDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

FILE: rtl/tfn_back.sv
// Back part: vertex store reads, cross product, serial isqrt and division.
// Depends on tfn_pkg.
module tfn_back import tfn_pkg::*; #(
  parameter int unsigned VertexDepth = 256,
  parameter int unsigned NormalScale = 256,
  parameter int unsigned CoordWidth  = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic [3*CoordWidth-1:0] wr_pos_i,
  input  job_t                   job_i,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  output logic [IdxW+3*NormW:0]  res_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i
);
  localparam int unsigned AW  = (VertexDepth > 1) ? $clog2(VertexDepth) : 1;
  localparam int unsigned DW  = CoordWidth + 1;      // edge
  localparam int unsigned NW  = 2 * DW + 1;          // cross component
  localparam int unsigned SW  = 2 * NW + 2;          // squared length
  localparam int unsigned LW  = (SW + 1) / 2;        // root
  localparam int unsigned SCW = $clog2(NormalScale + 1);
  localparam int unsigned MW  = NW + SCW;            // scaled magnitude
  localparam int unsigned CW  = 8;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_RDA = 10'b0000000010, S_RDB = 10'b0000000100,
    S_RDC  = 10'b0000001000, S_EDGE = 10'b0000010000, S_CROSS = 10'b0000100000,
    S_SQ   = 10'b0001000000, S_SQRT = 10'b0010000000, S_DIV = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q;
  logic [3*CoordWidth-1:0] mem [VertexDepth];
  logic [3*CoordWidth-1:0] rd_q;
  logic                    rd_ok_q, a_ok_q, b_ok_q;
  logic [3*CoordWidth-1:0] pa_q, pb_q;
  logic signed [DW-1:0]    u_q [3], v_q [3];
  logic signed [NW-1:0]    n_q [3];
  logic [SW-1:0]           rem_q;
  logic [LW-1:0]           root_q;
  logic [CW-1:0]           cnt_q;
  logic [1:0]              comp_q;
  logic [MW-1:0]           dividend_q;
  logic [NW:0]             drem_q;
  logic [NormW-1:0]        nout_q [3];
  logic                    degen_q;
  job_t                    job_q;
  logic [AW-1:0]           raddr;
  logic [IdxW-1:0]         ridx;

  always_comb begin
    unique case (state_q)
      S_IDLE:  ridx = job_i.index_a;
      S_RDA:   ridx = job_q.index_b;
      default: ridx = job_q.index_c;
    endcase
  end
  assign raddr = AW'(ridx);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && 32'(wr_idx_i) < VertexDepth) mem[AW'(wr_idx_i)] <= wr_pos_i;
    rd_q    <= mem[raddr];
    rd_ok_q <= 32'(ridx) < VertexDepth;
  end

  function automatic logic signed [DW-1:0] crd(logic [3*CoordWidth-1:0] p,
                                                logic ok, int k);
    return ok ? DW'($signed(p[k*CoordWidth +: CoordWidth])) : '0;
  endfunction

  assign job_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_OUT;
  assign res_o = {degen_q, nout_q[2], nout_q[1], nout_q[0], job_q.index_a};

  // Restoring square root step and magnitude for division.
  logic [LW+1:0]  trial;
  logic [LW-1:0]  len;
  logic signed [NW-1:0] ncur;
  logic [NW-1:0]  nmag;
  logic [NW+1:0]  dtry;
  logic [MW-1:0]  q_sat;
  logic signed [NormW:0] qs;

  always_comb begin
    trial  = {root_q, 2'b01};
    len    = (root_q == '0) ? LW'(1) : root_q;
    ncur   = n_q[comp_q];
    nmag   = ncur[NW-1] ? NW'(-ncur) : NW'(ncur);
    dtry   = {drem_q, dividend_q[MW-1]} - (NW+2)'(len);
    q_sat  = (dividend_q > MW'(512)) ? MW'(512) : dividend_q;
    qs     = ncur[NW-1] ? -(NormW+1)'(q_sat) : (NormW+1)'(q_sat);
    if (!ncur[NW-1] && q_sat > MW'(511)) qs = (NormW+1)'(511);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (job_valid_i) state_q <= S_RDA;
        S_RDA:   state_q <= S_RDB;
        S_RDB:   state_q <= S_RDC;
        S_RDC:   state_q <= S_EDGE;
        S_EDGE:  state_q <= S_CROSS;
        S_CROSS: state_q <= S_SQ;
        S_SQ:    state_q <= S_SQRT;
        S_SQRT:  if (cnt_q == CW'(LW-1)) state_q <= S_DIV;
        S_DIV:   if (cnt_q == CW'(MW+1) && comp_q == 2'd2) state_q <= S_OUT;
        S_OUT:   if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath; the radicand shifts out of sq_src_q two bits per root step.
  // Each component divides as load, MW quotient bits, then store.
  logic [SW-1:0] sq_src_q;
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (job_valid_i) job_q <= job_i;
      S_RDA:  begin pa_q <= rd_q; a_ok_q <= rd_ok_q; end
      S_RDB:  begin pb_q <= rd_q; b_ok_q <= rd_ok_q; end
      S_RDC:  for (int k = 0; k < 3; k++) begin
        u_q[k] <= crd(pb_q, b_ok_q, k) - crd(pa_q, a_ok_q, k);
        v_q[k] <= crd(rd_q, rd_ok_q, k) - crd(pa_q, a_ok_q, k);
      end
      S_EDGE: begin
        n_q[0] <= NW'(u_q[1] * v_q[2]) - NW'(u_q[2] * v_q[1]);
        n_q[1] <= NW'(u_q[2] * v_q[0]) - NW'(u_q[0] * v_q[2]);
        n_q[2] <= NW'(u_q[0] * v_q[1]) - NW'(u_q[1] * v_q[0]);
      end
      S_CROSS: begin
        sq_src_q <= SW'(n_q[0] * n_q[0]) + SW'(n_q[1] * n_q[1]);
      end
      S_SQ: begin
        sq_src_q <= sq_src_q + SW'(n_q[2] * n_q[2]);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      S_SQRT: begin
        // bring down two bits of the radicand, MSB pair first
        if ({rem_q[SW-3:0], sq_src_q[SW-1 -: 2]} >= SW'(trial)) begin
          rem_q  <= {rem_q[SW-3:0], sq_src_q[SW-1 -: 2]} - SW'(trial);
          root_q <= {root_q[LW-2:0], 1'b1};
        end else begin
          rem_q  <= {rem_q[SW-3:0], sq_src_q[SW-1 -: 2]};
          root_q <= {root_q[LW-2:0], 1'b0};
        end
        sq_src_q <= {sq_src_q[SW-3:0], 2'b00};
        degen_q  <= (cnt_q == '0) ? (sq_src_q == '0) : degen_q;
        cnt_q    <= (cnt_q == CW'(LW-1)) ? '0 : cnt_q + 1'b1;
        comp_q   <= '0;
        dividend_q <= '0;
        drem_q   <= '0;
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          dividend_q <= MW'(nmag * NormalScale);
          drem_q     <= '0;
          cnt_q      <= cnt_q + 1'b1;
        end else if (cnt_q == CW'(MW+1)) begin
          nout_q[comp_q] <= NormW'(qs);
          comp_q <= comp_q + 1'b1;
          cnt_q  <= '0;
        end else begin
          if (!dtry[NW+1]) begin
            drem_q     <= dtry[NW:0];
            dividend_q <= {dividend_q[MW-2:0], 1'b1};
          end else begin
            drem_q     <= {drem_q[NW-1:0], dividend_q[MW-1]};
            dividend_q <= {dividend_q[MW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/triangle_face_normal_unit.sv
// Triangle face normal unit: a write word stores a vertex position; a compute
// word names three vertices and yields the scaled unit normal of the
// triangle. The steps are the queue hand-off, vertex reads, edges, cross
// product and squared length, then the serial square root (one root bit per
// cycle) and the restoring divider per component (load, one quotient bit per
// cycle, store). A write word waits until no compute word is queued or in
// the back end, so a pending compute never sees a later write. Up to two
// compute words wait in a queue; the back end takes the next one in the cycle
// after the result word is taken. Depends on tfn_pkg, tfn_front, tfn_back.
module triangle_face_normal_unit import tfn_pkg::*; #(
  parameter int unsigned VERTEX_DEPTH = 256,
  parameter int unsigned NORMAL_SCALE = 256,
  parameter int unsigned COORD_WIDTH  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low to high: index_a, index_b, index_c, pos_x, pos_y, pos_z, pad
  input  logic [63:0] s_axis_tdata,
  // tuser: mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low to high: target_index, normal_x, normal_y, normal_z, pad
  output logic [39:0] m_axis_tdata,
  // tuser: degenerate
  output logic        m_axis_tuser
);
  job_t in_job, job;
  logic wr_en, job_valid, job_ready;
  logic [IdxW+3*NormW:0] res;
  logic [3*COORD_WIDTH-1:0] wr_pos;

  assign in_job = '{index_a: s_axis_tdata[7:0], index_b: s_axis_tdata[15:8],
                    index_c: s_axis_tdata[23:16]};
  for (genvar k = 0; k < 3; k++) begin : g_pos
    assign wr_pos[k*COORD_WIDTH +: COORD_WIDTH] =
      s_axis_tdata[24 + k*FieldW +: COORD_WIDTH];
  end

  tfn_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser),  .in_job_i   (in_job),
    .wr_en_o    (wr_en),
    .job_o      (job), .job_valid_o (job_valid), .job_ready_i (job_ready)
  );

  tfn_back #(
    .VertexDepth (VERTEX_DEPTH), .NormalScale (NORMAL_SCALE),
    .CoordWidth  (COORD_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .wr_en_i (wr_en), .wr_idx_i (s_axis_tdata[7:0]), .wr_pos_i (wr_pos),
    .job_i (job), .job_valid_i (job_valid), .job_ready_o (job_ready),
    .res_o (res), .res_valid_o (m_axis_tvalid), .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, res[IdxW+3*NormW-1:0]};
  assign m_axis_tuser = res[IdxW+3*NormW];
endmodule
